FILE: design/bas_pkg.sv
package bas_pkg;

    // Timer width default; the top level hands its parameter down.
    localparam int TIMER_BITS_DEF = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Reset values of the configuration registers
    localparam logic [3:0]  MAX_REQUESTS_RST = 4'd2;
    localparam logic [15:0] SUPP_TIMEOUT_RST = 16'd30;
    localparam logic [15:0] SERV_TIMEOUT_RST = 16'd30;

    // Bit positions in the event latch vector
    localparam int LT_ABORT  = 0;
    localparam int LT_START  = 1;
    localparam int LT_RXRESP = 2;
    localparam int LT_AREQ   = 3;
    localparam int LT_ASUCC  = 4;
    localparam int LT_AFAIL  = 5;
    localparam int LT_W      = 6;

    typedef enum logic [2:0] {
        ST_INIT = 3'd0,
        ST_IDLE = 3'd1,
        ST_RESP = 3'd2,
        ST_REQ  = 3'd3,
        ST_SUCC = 3'd4,
        ST_FAIL = 3'd5,
        ST_TOUT = 3'd6
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_TX_REQ = 3'd1,
        ACT_SEND   = 3'd2,
        ACT_SUCC   = 3'd3,
        ACT_FAIL   = 3'd4,
        ACT_ABORT  = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_REQUESTS = 2'd0,
        CFG_SUPP_TIMEOUT = 2'd1,
        CFG_SERV_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  max_requests;
        logic [15:0] supplicant_timeout;
        logic [15:0] server_timeout;
    } t_cfg;

    typedef struct packed {
        logic       port_auto;
        logic       init_level;
        logic       abort_pulse;
        logic       start_pulse;
        logic       supp_response;
        logic       server_request;
        logic       server_accept;
        logic       server_reject;
        logic       tick;
        logic       port_unauth;
        logic       load_id;
        logic [7:0] new_server_id;
    } t_in_item;

    typedef struct packed {
        t_state     fsm_state;
        t_action    action;
        logic [7:0] frame_id;
        logic       frame_id_valid;
        logic       success_pulse;
        logic       fail_pulse;
        logic       timeout_flag;
        logic [3:0] retry_count;
    } t_out_item;

    // Machine context apart from the timer, whose width is a parameter
    typedef struct packed {
        t_state          fsm;
        logic [3:0]      req_count;
        logic [LT_W-1:0] latches;
        logic [7:0]      server_id;
        logic            server_id_ok;
        logic [7:0]      current_id;
        logic            current_id_ok;
        logic            timeout_level;
    } t_ctx;

endpackage

FILE: design/bas_cfg.sv
module bas_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bas_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bas_pkg::t_cfg                     o_cfg
);
    import bas_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_REQUESTS: n_cfg.max_requests       = i_cfg_data[3:0];
                CFG_SUPP_TIMEOUT: n_cfg.supplicant_timeout = i_cfg_data;
                CFG_SERV_TIMEOUT: n_cfg.server_timeout     = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_requests       <= MAX_REQUESTS_RST;
            r_cfg.supplicant_timeout <= SUPP_TIMEOUT_RST;
            r_cfg.server_timeout     <= SERV_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/bas_step.sv
module bas_step #(
    parameter int TIMER_BITS = bas_pkg::TIMER_BITS_DEF
) (
    input  bas_pkg::t_ctx         i_ctx,
    input  logic [TIMER_BITS-1:0] i_timer,
    input  bas_pkg::t_cfg         i_cfg,
    input  bas_pkg::t_in_item     i_item,
    output bas_pkg::t_ctx         o_ctx,
    output logic [TIMER_BITS-1:0] o_timer,
    output bas_pkg::t_out_item    o_item
);
    import bas_pkg::*;

    logic [LT_W-1:0]       lat;
    logic [7:0]            sid;
    logic                  sid_ok;
    logic [TIMER_BITS-1:0] tmr;
    logic                  tmr_zero;
    logic                  force_init;
    logic                  moved;
    t_state                nxt;

    // Capture pulses, take the new identifier, apply the tick
    always_comb begin
        lat = i_ctx.latches;
        lat[LT_ABORT]  = lat[LT_ABORT]  | i_item.abort_pulse;
        lat[LT_START]  = lat[LT_START]  | i_item.start_pulse;
        lat[LT_RXRESP] = lat[LT_RXRESP] | i_item.supp_response;
        lat[LT_AREQ]   = lat[LT_AREQ]   | i_item.server_request;
        lat[LT_ASUCC]  = lat[LT_ASUCC]  | i_item.server_accept;
        lat[LT_AFAIL]  = lat[LT_AFAIL]  | i_item.server_reject;
        sid    = i_item.load_id ? i_item.new_server_id : i_ctx.server_id;
        sid_ok = i_item.load_id | i_ctx.server_id_ok;
        tmr    = (i_item.tick && (i_timer != '0)) ? i_timer - 1'b1 : i_timer;
    end

    assign tmr_zero   = (tmr == '0);
    assign force_init = !i_item.port_auto || i_item.init_level || lat[LT_ABORT];

    // Next state
    always_comb begin
        nxt   = i_ctx.fsm;
        moved = 1'b1;
        if (force_init) begin
            nxt = ST_INIT;
        end else begin
            unique case (i_ctx.fsm)
                ST_REQ: begin
                    if (lat[LT_RXRESP])                                       nxt = ST_RESP;
                    else if (tmr_zero && (i_ctx.req_count != i_cfg.max_requests)) nxt = ST_REQ;
                    else if (tmr_zero)                                        nxt = ST_TOUT;
                    else                                                      moved = 1'b0;
                end
                ST_RESP: begin
                    if (lat[LT_RXRESP])     nxt = ST_RESP;
                    else if (lat[LT_AREQ])  nxt = ST_REQ;
                    else if (tmr_zero)      nxt = ST_TOUT;
                    else if (lat[LT_AFAIL]) nxt = ST_FAIL;
                    else if (lat[LT_ASUCC]) nxt = ST_SUCC;
                    else                    moved = 1'b0;
                end
                ST_IDLE: begin
                    if (lat[LT_START]) nxt = ST_RESP;
                    else               moved = 1'b0;
                end
                default: nxt = ST_IDLE;
            endcase
        end
    end

    // Entry actions and result
    always_comb begin
        o_ctx              = i_ctx;
        o_ctx.latches      = lat;
        o_ctx.server_id    = sid;
        o_ctx.server_id_ok = sid_ok;
        o_timer            = tmr;
        o_item             = '0;
        o_item.action      = ACT_NONE;
        if (moved) begin
            o_ctx.fsm = nxt;
            unique case (nxt)
                ST_REQ: begin
                    o_ctx.current_id    = sid;
                    o_ctx.current_id_ok = sid_ok;
                    o_item.action       = ACT_TX_REQ;
                    o_timer             = TIMER_BITS'(i_cfg.supplicant_timeout);
                    o_ctx.req_count     = i_ctx.req_count + 4'd1;
                end
                ST_RESP: begin
                    o_ctx.latches[LT_AREQ]   = 1'b0;
                    o_ctx.latches[LT_ASUCC]  = 1'b0;
                    o_ctx.latches[LT_RXRESP] = 1'b0;
                    o_ctx.latches[LT_AFAIL]  = 1'b0;
                    o_ctx.timeout_level      = 1'b0;
                    o_timer                  = TIMER_BITS'(i_cfg.server_timeout);
                    o_ctx.req_count          = 4'd0;
                    o_item.action            = ACT_SEND;
                end
                ST_SUCC: begin
                    o_ctx.current_id     = sid;
                    o_ctx.current_id_ok  = sid_ok;
                    o_item.action        = ACT_SUCC;
                    o_item.success_pulse = 1'b1;
                end
                ST_FAIL: begin
                    o_ctx.current_id    = sid;
                    o_ctx.current_id_ok = sid_ok;
                    o_item.action       = ACT_FAIL;
                    o_item.fail_pulse   = 1'b1;
                end
                ST_TOUT: begin
                    o_item.action       = i_item.port_unauth ? ACT_FAIL : ACT_NONE;
                    o_ctx.timeout_level = 1'b1;
                end
                ST_IDLE: begin
                    o_ctx.latches[LT_START] = 1'b0;
                    o_ctx.req_count         = 4'd0;
                end
                default: begin
                    o_ctx.latches[LT_ABORT] = 1'b0;
                    o_item.action           = ACT_ABORT;
                end
            endcase
        end
        o_item.fsm_state      = o_ctx.fsm;
        o_item.frame_id       = o_ctx.current_id;
        o_item.frame_id_valid = o_ctx.current_id_ok;
        o_item.timeout_flag   = o_ctx.timeout_level;
        o_item.retry_count    = o_ctx.req_count;
    end

endmodule

FILE: design/backend_auth_state_machine_top.sv
// Backend authenticator state machine (802.1X style), one evaluation step per
// input transfer.
// Input channel (i_in_valid / o_in_ready / i_in_item): each transfer carries
// the port levels, the event pulses, a timer tick and an optional new server
// identifier. Output channel (o_out_valid / i_out_ready / o_out_item): one
// result transfer per input transfer, in order: state, frame action, frame
// identifier and status flags.
// Configuration: write i_cfg_data into register i_cfg_idx while i_cfg_we is
// high (0 max_requests, 1 supplicant_timeout, 2 server_timeout); index 3 is
// ignored. Write only while no step is in flight.
// Path: a transfer lands in the input register; the step runs from there
// into the result register once that register is free or being emptied.
// Throughput: one step per cycle while the receiver keeps up, set by the
// single combinational step between the two registers.
// Reset (synchronous, active low): machine in initialize, counters, timer and
// latches clear, identifiers invalid, configuration back to 2 / 30 / 30.
// Receiver stall: the result register holds; the input register still takes
// one more transfer, then o_in_ready drops until the result is taken.
module backend_auth_state_machine_top #(
    parameter int TIMER_BITS = bas_pkg::TIMER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bas_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bas_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [bas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bas_pkg::*;

    t_cfg                  cfg;

    // Input register
    logic                  r_in_valid;
    t_in_item              r_in_item;

    // Machine state
    t_ctx                  r_ctx;
    logic [TIMER_BITS-1:0] r_timer;
    t_ctx                  n_ctx;
    logic [TIMER_BITS-1:0] n_timer;

    // Result register
    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_out_item             n_out_item;

    logic                  step_go;

    bas_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bas_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_ctx   (r_ctx),
        .i_timer (r_timer),
        .i_cfg   (cfg),
        .i_item  (r_in_item),
        .o_ctx   (n_ctx),
        .o_timer (n_timer),
        .o_item  (n_out_item)
    );

    // Run a step when an item waits and the result register is free or
    // being emptied this cycle.
    assign step_go    = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new item when the input register is empty or drains now.
    assign o_in_ready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Advance the machine only on a step; hold otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx   <= '{fsm: ST_INIT, default: '0};
            r_timer <= '0;
        end else if (step_go) begin
            r_ctx   <= n_ctx;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
